FILE: design/bclpd_pkg.sv
`default_nettype none

package bclpd_pkg;

  // event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_CLICK   = 3'd1;
  localparam logic [2:0] EV_DOUBLE  = 3'd2;
  localparam logic [2:0] EV_LONG    = 3'd3;
  localparam logic [2:0] EV_LONG_UP = 3'd4;

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HELD   = 2'd1;
  localparam logic [1:0] PH_GAP    = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_GAP        = 2'd2;

  localparam logic [3:0] DEBOUNCE_RST   = 4'd3;
  localparam logic [7:0] LONG_PRESS_RST = 8'd30;
  localparam logic [7:0] GAP_RST        = 8'd20;

  localparam logic [3:0] BOUNCE_MAX = 4'd15;
  localparam logic [7:0] TICK_MAX   = 8'd255;
  localparam logic [1:0] PRESS_MAX  = 2'd3;

  typedef struct packed {
    logic [3:0] debounce_ticks;
    logic [7:0] long_press_ticks;
    logic [7:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic       stable_level;
    logic [3:0] bounce_count;
    logic [1:0] phase;
    logic [7:0] tick_count;
    logic [1:0] press_count;
  } state_t;

endpackage

`default_nettype wire

FILE: design/bclpd_step.sv
`default_nettype none

// One tick of debounce plus click/long-press phase machine, combinational.
module bclpd_step (
  input  wire                 pin_level,
  input  bclpd_pkg::cfg_t     cfg,
  input  bclpd_pkg::state_t   st,
  output bclpd_pkg::state_t   st_nxt,
  output logic [2:0]          event_code
);

  logic [1:0] ph;
  logic [7:0] tick1;
  logic [3:0] bounce1;
  logic       stable1;
  logic [3:0] bounce_nxt;

  always_comb begin
    // unreachable phase acts as idle
    ph = (st.phase == bclpd_pkg::PH_UNUSED) ? bclpd_pkg::PH_IDLE : st.phase;

    tick1 = st.tick_count;
    if (ph != bclpd_pkg::PH_IDLE && st.tick_count != bclpd_pkg::TICK_MAX) begin
      tick1 = st.tick_count + 8'd1;
    end

    // debounce
    stable1    = st.stable_level;
    bounce_nxt = 4'd0;
    bounce1    = st.bounce_count;
    if (st.stable_level != pin_level) begin
      if (st.bounce_count != bclpd_pkg::BOUNCE_MAX) begin
        bounce1 = st.bounce_count + 4'd1;
      end
      if (bounce1 >= cfg.debounce_ticks) begin
        stable1    = pin_level;
        bounce_nxt = 4'd0;
      end else begin
        bounce_nxt = bounce1;
      end
    end

    st_nxt              = st;
    st_nxt.phase        = ph;
    st_nxt.tick_count   = tick1;
    st_nxt.stable_level = stable1;
    st_nxt.bounce_count = bounce_nxt;
    event_code          = bclpd_pkg::EV_NONE;

    case (ph)
      bclpd_pkg::PH_IDLE: begin
        if (!stable1) begin
          st_nxt.tick_count  = 8'd0;
          st_nxt.press_count = 2'd1;
          st_nxt.phase       = bclpd_pkg::PH_HELD;
        end
      end
      bclpd_pkg::PH_HELD: begin
        if (stable1) begin
          if (tick1 >= cfg.long_press_ticks) begin
            event_code         = bclpd_pkg::EV_LONG_UP;
            st_nxt.phase       = bclpd_pkg::PH_IDLE;
            st_nxt.press_count = 2'd0;
          end else begin
            st_nxt.tick_count = 8'd0;
            st_nxt.phase      = bclpd_pkg::PH_GAP;
          end
        end else if (tick1 >= cfg.long_press_ticks) begin
          event_code         = bclpd_pkg::EV_LONG;
          st_nxt.press_count = 2'd0;
        end
      end
      default: begin
        // gap phase
        if (tick1 >= cfg.gap_ticks) begin
          st_nxt.phase = bclpd_pkg::PH_IDLE;
          if (st.press_count == 2'd1) begin
            event_code = bclpd_pkg::EV_CLICK;
          end else if (st.press_count == 2'd2) begin
            event_code = bclpd_pkg::EV_DOUBLE;
          end
        end else if (!stable1) begin
          if (st.press_count != bclpd_pkg::PRESS_MAX) begin
            st_nxt.press_count = st.press_count + 2'd1;
          end
          st_nxt.tick_count = 8'd0;
          st_nxt.phase      = bclpd_pkg::PH_HELD;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/button_click_long_press_detector_top.sv
// Button click / double click / long press detector.
//
// Input channel (in_valid/in_ready): one raw pin sample per item, 0 = pressed.
// Result channel (out_valid/out_ready): one result per input item, carrying the
// event code (none, click, double click, long press held, long press released)
// and the debounced level after that sample.
// Config port: cfg_we writes cfg_wdata into the register chosen by cfg_index
// (0 debounce ticks, 1 long-press ticks, 2 gap ticks); index 3 is ignored.
// Write only while the block is idle.
//
// Results are registered (output register, or skid register on a stall).
// Throughput: one item per cycle while in_ready is high; the whole tick
// update is one pass of logic between the state and output registers.
// A two-entry output (output register plus skid register) keeps in_ready
// high for one more item after out_ready drops; with both full, in_ready
// falls until the receiver takes a result.
// Reset (rst_n low, synchronous): registers back to 3/30/20, level released,
// counters and phase cleared, no results pending.
`default_nettype none

module button_click_long_press_detector_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_pin_level,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] out_event_code,
  output logic       out_clean_level,
  input  wire        cfg_we,
  input  wire  [1:0] cfg_index,
  input  wire  [7:0] cfg_wdata
);

  bclpd_pkg::cfg_t   cfg_r;
  bclpd_pkg::state_t st_r;
  bclpd_pkg::state_t st_nxt;
  logic [2:0]        ev_nxt;

  logic       out_valid_r;
  logic [2:0] out_event_r;
  logic       out_level_r;
  logic       skid_valid_r;
  logic [2:0] skid_event_r;
  logic       skid_level_r;

  logic push;
  logic pop;

  assign in_ready        = !skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_event_code  = out_event_r;
  assign out_clean_level = out_level_r;

  assign push = in_valid && in_ready;
  assign pop  = out_valid_r && out_ready;

  bclpd_step u_step (
    .pin_level  (in_pin_level),
    .cfg        (cfg_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .event_code (ev_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= bclpd_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ticks <= bclpd_pkg::LONG_PRESS_RST;
      cfg_r.gap_ticks        <= bclpd_pkg::GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bclpd_pkg::REG_DEBOUNCE:   cfg_r.debounce_ticks   <= cfg_wdata[3:0];
        bclpd_pkg::REG_LONG_PRESS: cfg_r.long_press_ticks <= cfg_wdata;
        bclpd_pkg::REG_GAP:        cfg_r.gap_ticks        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.stable_level <= 1'b1;
      st_r.bounce_count <= 4'd0;
      st_r.phase        <= bclpd_pkg::PH_IDLE;
      st_r.tick_count   <= 8'd0;
      st_r.press_count  <= 2'd0;
    end else if (push) begin
      st_r <= st_nxt;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_event_r <= skid_event_r;
        out_level_r <= skid_level_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_event_r <= ev_nxt;
        skid_level_r <= st_nxt.stable_level;
      end else begin
        out_event_r <= ev_nxt;
        out_level_r <= st_nxt.stable_level;
      end
    end
  end

  // skid entry only ever fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // a stalled result plus a new item must land in the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push && out_valid_r && !out_ready |=> skid_valid_r)
    else $error("item lost while output stalled");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_event_r <= bclpd_pkg::EV_LONG_UP))
    else $error("event code out of range");

  a_phase_reach: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (st_r.phase != bclpd_pkg::PH_UNUSED))
    else $error("unused phase entered");

  // an accepted item with both outputs free shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    push && !out_valid_r |=> out_valid_r && (out_level_r == st_r.stable_level))
    else $error("result missing one cycle after accept");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // overall run limit
  localparam int unsigned CYCLE_LIMIT = 200000;
  // long receiver stall used to fill the output buffer
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned MAX_REPORTS = 100;
  // index 3 is decoded as no register at all
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0] code;
    logic       level;
  } tick_result_t;

  // one directed item: pin sample, whether the result is typed in, typed result
  typedef struct packed {
    logic       pin;
    logic       typed;
    logic [2:0] code;
    logic       level;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_pin_level = 1'b1;
  logic       out_ready = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = bclpd_pkg::REG_DEBOUNCE;
  logic [7:0] cfg_wdata = 8'd0;
  wire        in_ready;
  wire        out_valid;
  wire  [2:0] out_event_code;
  wire        out_clean_level;

  button_click_long_press_detector_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pin_level   (in_pin_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .out_clean_level(out_clean_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Predictor state: debouncer and phase machine, plus the live thresholds.
  bclpd_pkg::state_t btn;
  bclpd_pkg::cfg_t   knobs;

  // Results still owed by the block, oldest first.
  tick_result_t pending_events[$];
  // Pin samples of the gesture being played out.
  logic         pin_q[$];
  logic         run_lvl;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_done = 0;

  // Directed items, run with debounce 1, long press 3, gap 2 so every event
  // fits in a short stretch. Only the first two results are typed in.
  row_t rows [25] = '{
    {1'b1, 1'b1, bclpd_pkg::EV_NONE, 1'b1},  // released sample straight after reset
    {1'b0, 1'b1, bclpd_pkg::EV_NONE, 1'b0},  // press taken on its first tick
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},  // short release: into the gap
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},  // gap expires: single click
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},  // second press inside the gap
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},  // double click
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},  // long press reached
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},  // still held: long press again
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},  // long press release
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b0, 1'b0, bclpd_pkg::EV_NONE, 1'b0},  // third press: saturates the press count
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0},
    {1'b1, 1'b0, bclpd_pkg::EV_NONE, 1'b0}   // gap expires after a triple: nothing
  };

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("button_click_long_press_detector_top regression: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (errors < MAX_REPORTS)
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // One tick of the detector: updates btn and returns what the block reports.
  function automatic tick_result_t step_button(input logic pin);
    tick_result_t r;
    r.code = bclpd_pkg::EV_NONE;
    if (btn.phase == bclpd_pkg::PH_UNUSED)
      btn.phase = bclpd_pkg::PH_IDLE;
    if (btn.phase != bclpd_pkg::PH_IDLE && btn.tick_count != bclpd_pkg::TICK_MAX)
      btn.tick_count++;

    // debouncer
    if (btn.stable_level != pin) begin
      if (btn.bounce_count != bclpd_pkg::BOUNCE_MAX)
        btn.bounce_count++;
      if (btn.bounce_count >= knobs.debounce_ticks) begin
        btn.stable_level = pin;
        btn.bounce_count = '0;
      end
    end else begin
      btn.bounce_count = '0;
    end

    if (btn.phase == bclpd_pkg::PH_IDLE) begin
      if (!btn.stable_level) begin
        btn.tick_count  = '0;
        btn.press_count = 2'd1;
        btn.phase       = bclpd_pkg::PH_HELD;
      end
    end else if (btn.phase == bclpd_pkg::PH_HELD) begin
      if (btn.stable_level) begin
        if (btn.tick_count >= knobs.long_press_ticks) begin
          r.code          = bclpd_pkg::EV_LONG_UP;
          btn.phase       = bclpd_pkg::PH_IDLE;
          btn.press_count = '0;
        end else begin
          btn.tick_count = '0;
          btn.phase      = bclpd_pkg::PH_GAP;
        end
      end else if (btn.tick_count >= knobs.long_press_ticks) begin
        r.code          = bclpd_pkg::EV_LONG;
        btn.press_count = '0;
      end
    end else begin
      // gap after a short press
      if (btn.tick_count >= knobs.gap_ticks) begin
        btn.phase = bclpd_pkg::PH_IDLE;
        if (btn.press_count == 2'd1)
          r.code = bclpd_pkg::EV_CLICK;
        else if (btn.press_count == 2'd2)
          r.code = bclpd_pkg::EV_DOUBLE;
      end else if (!btn.stable_level) begin
        if (btn.press_count != bclpd_pkg::PRESS_MAX)
          btn.press_count++;
        btn.tick_count = '0;
        btn.phase      = bclpd_pkg::PH_HELD;
      end
    end
    r.level = btn.stable_level;
    return r;
  endfunction

  // Writes all three thresholds, junk in the unused bits, and the spare index.
  // Called only with nothing in flight.
  task automatic set_config(input logic [3:0] deb, input logic [7:0] lp,
                            input logic [7:0] gp);
    logic [7:0] dval;
    dval = {4'($urandom_range(0, 15)), deb};
    cfg_we    <= 1'b1;
    cfg_index <= bclpd_pkg::REG_DEBOUNCE;
    cfg_wdata <= dval;
    @(posedge clk);
    knobs.debounce_ticks = dval[3:0];
    cfg_index <= bclpd_pkg::REG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    knobs.long_press_ticks = lp;
    cfg_index <= bclpd_pkg::REG_GAP;
    cfg_wdata <= gp;
    @(posedge clk);
    knobs.gap_ticks = gp;
    // spare index must leave every register alone
    cfg_index <= REG_SPARE;
    cfg_wdata <= 8'($urandom_range(0, 255));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one pin sample and waits for it to be taken. The expected result is
  // the typed one where given, else the predictor's.
  task automatic send_pin(input logic pin, input logic typed, input tick_result_t want);
    tick_result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= pin;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    got = step_button(pin);
    pending_events.push_back(typed ? want : got);
  endtask

  // Lets the block drain before the thresholds change or the run ends.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One run of a level: mostly lengths around the threshold that matters for
  // it, with occasional contact bounce in front and a little pure noise.
  task automatic queue_run(input logic lvl);
    int unsigned thr;
    int unsigned len;
    thr = (lvl ? knobs.gap_ticks : knobs.long_press_ticks) + knobs.debounce_ticks + 1;
    case ($urandom_range(0, 9))
      0: begin
        repeat ($urandom_range(1, 4)) pin_q.push_back(1'($urandom_range(0, 1)));
        len = 0;
      end
      1, 2, 3, 4: len = $urandom_range(1, thr);
      default:    len = $urandom_range(thr, thr + 8);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        pin_q.push_back(lvl);
        pin_q.push_back(!lvl);
      end
    end
    repeat (len) pin_q.push_back(lvl);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch("unexpected result, event_code", out_event_code, -1);
      end else begin
        want = pending_events.pop_front();
        if (out_event_code !== want.code)
          flag_mismatch("event_code", out_event_code, want.code);
        if (out_clean_level !== want.level)
          flag_mismatch("clean_level", out_clean_level, want.level);
      end
    end
  end

  initial begin
    tick_result_t want;
    int unsigned  n_items;
    logic [3:0]   deb;
    logic [7:0]   lp;
    logic [7:0]   gp;

    // predictor starts from the reset state
    btn.stable_level       = 1'b1;
    btn.bounce_count       = '0;
    btn.phase              = bclpd_pkg::PH_IDLE;
    btn.tick_count         = '0;
    btn.press_count        = '0;
    knobs.debounce_ticks   = bclpd_pkg::DEBOUNCE_RST;
    knobs.long_press_ticks = bclpd_pkg::LONG_PRESS_RST;
    knobs.gap_ticks        = bclpd_pkg::GAP_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalling
    send_idle_pct = 19;
    recv_idle_pct = 66;

    // directed walk through click, double click, long press and triple
    set_config(4'd1, 8'd3, 8'd2);
    foreach (rows[i]) begin
      want.code  = rows[i].code;
      want.level = rows[i].level;
      send_pin(rows[i].pin, rows[i].typed, want);
    end
    drain();

    // random gestures under a series of threshold settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          deb = bclpd_pkg::DEBOUNCE_RST;
          lp  = bclpd_pkg::LONG_PRESS_RST;
          gp  = bclpd_pkg::GAP_RST;
          n_items = 200;
        end
        1: begin deb = 4'd1;  lp = 8'd1;   gp = 8'd1;   n_items = 150; end
        2: begin deb = 4'd15; lp = 8'd255; gp = 8'd255; n_items = 600; end
        3: begin deb = 4'd0;  lp = 8'd0;   gp = 8'd0;   n_items = 150; end
        4: begin
          deb = 4'($urandom_range(0, 15));
          lp  = 8'($urandom_range(1, 60));
          gp  = 8'($urandom_range(1, 60));
          n_items = 150;
        end
        default: begin
          deb = 4'($urandom_range(0, 4));
          lp  = 8'($urandom_range(0, 255));
          gp  = 8'($urandom_range(0, 20));
          n_items = 150;
        end
      endcase

      // swap the idling pattern, then run flat out for the last phases
      if (p == 2) begin
        send_idle_pct = 66;
        recv_idle_pct = 19;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      set_config(deb, lp, gp);
      pin_q.delete();
      run_lvl = 1'b0;

      // long receiver hold-off while the sender keeps offering items
      if (p == 4)
        hold_asks++;

      want = '0;
      repeat (n_items) begin
        if (pin_q.size() == 0) begin
          queue_run(run_lvl);
          run_lvl = !run_lvl;
        end
        if (pin_q.size() != 0)
          send_pin(pin_q.pop_front(), 1'b0, want);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && pending_events.size() == 0)
      $display("button_click_long_press_detector_top regression: pass");
    else
      $display("button_click_long_press_detector_top regression: fail");
    $finish;
  end

endmodule

FILE: files.f
design/bclpd_pkg.sv
design/bclpd_step.sv
design/button_click_long_press_detector_top.sv
bench/testbench.sv
